[hdl/pbsc_pkg.sv]
// Shared types and constants for the planar base position settle controller.
// Used by planar_base_position_settle_controller_core; depends on nothing else.
package pbsc_pkg;

  // Number of selectable front-distance targets (indexes 0..3).
  localparam int unsigned NUM_POSITIONS = 4;

  // Configuration register indexes.
  localparam logic [2:0] REG_LEFT_TARGET    = 3'd0;
  localparam logic [2:0] REG_LEFT_DEADBAND  = 3'd1;
  localparam logic [2:0] REG_FRONT_DEADBAND = 3'd2;
  localparam logic [2:0] REG_ANGLE_DEADBAND = 3'd3;
  localparam logic [2:0] REG_LEFT_MIN       = 3'd4;
  localparam logic [2:0] REG_LEFT_MAX       = 3'd5;
  localparam logic [2:0] REG_FRONT_MIN      = 3'd6;
  localparam logic [2:0] REG_FRONT_MAX      = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [11:0] LEFT_TARGET_RST    = 12'd260;
  localparam logic [9:0]  LEFT_DEADBAND_RST  = 10'd50;
  localparam logic [9:0]  FRONT_DEADBAND_RST = 10'd30;
  localparam logic [9:0]  ANGLE_DEADBAND_RST = 10'd30;
  localparam logic [11:0] LEFT_MIN_RST       = 12'd100;
  localparam logic [11:0] LEFT_MAX_RST       = 12'd1000;
  localparam logic [11:0] FRONT_MIN_RST      = 12'd150;
  localparam logic [11:0] FRONT_MAX_RST      = 12'd2250;

  // Fixed angle window, in mrad.
  localparam logic signed [12:0] ANGLE_WINDOW = 13'sd500;

  // Settle requirements and counter limits.
  localparam logic [3:0] LEFT_SETTLE_NEED  = 4'd4;
  localparam logic [3:0] FRONT_SETTLE_NEED = 4'd5;
  localparam logic [3:0] ANGLE_SETTLE_NEED = 4'd4;
  localparam logic [3:0] COUNT_MAX         = 4'd15;
  localparam logic [2:0] ALL_SETTLE_NEED   = 3'd6;
  localparam logic [2:0] ALL_COUNT_MAX     = 3'd7;

  // Velocity magnitude limits per axis.
  localparam logic [9:0] FWD_VMIN  = 10'd100;
  localparam logic [9:0] FWD_VMAX  = 10'd600;
  localparam logic [9:0] SIDE_VMIN = 10'd100;
  localparam logic [9:0] SIDE_VMAX = 10'd200;
  localparam logic [9:0] TURN_VMIN = 10'd100;
  localparam logic [9:0] TURN_VMAX = 10'd300;

  typedef enum logic [1:0] {
    STATUS_MOVING  = 2'd0,
    STATUS_STOP    = 2'd1,
    STATUS_ARRIVED = 2'd2
  } status_t;

  // Front-distance target in mm for each position index.
  function automatic logic [11:0] front_target(input logic [1:0] idx);
    logic [11:0] t;
    case (idx)
      2'd0:    t = 12'd2200;
      2'd1:    t = 12'd1600;
      2'd2:    t = 12'd1000;
      2'd3:    t = 12'd400;
      default: t = 12'd2200;
    endcase
    return t;
  endfunction

endpackage

[hdl/planar_base_position_settle_controller_core.sv]
// Top level of the planar base position settle controller.
// Depends on pbsc_pkg for constants, the status type and the target table.
//
// Usage:
//   The slave stream carries one item per transaction. s_tuser is the mode:
//   0 is a control tick with measurements, 1 is a position command whose
//   index travels in s_tdata. A command selects one of the front targets and
//   gives no result; a tick with no active target clears the settle counters
//   and gives no result. A tick with a target gives one result on the master
//   stream: three velocities in m_tdata and the status in m_tuser.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   while the block is idle; each write takes effect at the next edge.
//   An accepted item sits in the input register; its result is loaded into
//   the output register when the item leaves it, and m_tvalid rises with that
//   load. Throughput is one item per cycle while the receiver keeps up; the
//   settle state is updated in the same cycle the result is formed, so
//   back-to-back ticks see each other's effect.
//   When the receiver stalls, the result waits in the output register and
//   one more item waits in the input register; s_tready then drops.
//   Reset (synchronous, active high) empties both registers, drops the
//   target, clears all counters and restores the register defaults.
module planar_base_position_settle_controller_core
  import pbsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, from bit 0: left_dist_mm[13:0], front_dist_mm[27:14],
  // wall_angle_mrad[40:28], position_request[56:41], zero pad [63:57].
  input  logic [63:0] s_tdata,
  // s_tuser: mode[0].
  input  logic        s_tuser,
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, from bit 0: vel_forward[10:0], vel_sideways[19:11],
  // vel_turn[29:20], zero pad [31:30].
  output logic [31:0] m_tdata,
  // m_tuser: status[1:0].
  output logic [1:0]  m_tuser,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  // Configuration registers.
  logic [11:0] left_target;
  logic [9:0]  left_deadband;
  logic [9:0]  front_deadband;
  logic [9:0]  angle_deadband;
  logic [11:0] left_min;
  logic [11:0] left_max;
  logic [11:0] front_min;
  logic [11:0] front_max;

  // Controller state.
  logic       target_valid, target_valid_next;
  logic [1:0] target_index, target_index_next;
  logic [3:0] left_count, left_count_next;
  logic [3:0] front_count, front_count_next;
  logic [3:0] angle_count, angle_count_next;
  logic [2:0] all_count, all_count_next;

  // Input register.
  logic        s1_valid;
  logic        s1_mode;
  logic [56:0] s1_data;

  logic        s1_fire;
  logic        out_free;
  logic        res_valid;
  logic signed [10:0] res_vf;
  logic signed [8:0]  res_vs;
  logic signed [9:0]  res_vt;
  status_t     res_status;

  logic signed [13:0] in_left;
  logic signed [13:0] in_front;
  logic signed [12:0] in_angle;
  logic signed [15:0] in_request;
  logic               request_ok;
  logic               window_fail;
  logic signed [14:0] err_left, err_front, err_angle;
  logic               unset_left, unset_front, unset_angle;
  logic signed [10:0] v_left, v_front, v_turn;
  logic               all_ok;
  logic [2:0]         all_inc;

  // Magnitude of a 15-bit signed error.
  function automatic logic [14:0] err_mag(input logic signed [14:0] e);
    return e[14] ? 15'(-e) : 15'(e);
  endfunction

  // Velocity of minus the error, magnitude clamped to [vmin, vmax].
  function automatic logic signed [10:0] axis_vel(input logic signed [14:0] e,
                                                  input logic [9:0] vmin,
                                                  input logic [9:0] vmax);
    logic [14:0] m;
    logic [9:0]  c;
    m = err_mag(e);
    if (m > {5'd0, vmax}) begin
      c = vmax;
    end else if (m < {5'd0, vmin}) begin
      c = vmin;
    end else begin
      c = m[9:0];
    end
    return e[14] ? $signed({1'b0, c}) : -$signed({1'b0, c});
  endfunction

  // Saturating settle counter; cleared when the axis is outside its band.
  function automatic logic [3:0] count_step(input logic unset, input logic [3:0] c);
    if (unset) begin
      return 4'd0;
    end else if (c == COUNT_MAX) begin
      return COUNT_MAX;
    end
    return c + 4'd1;
  endfunction

  assign in_left    = $signed(s1_data[13:0]);
  assign in_front   = $signed(s1_data[27:14]);
  assign in_angle   = $signed(s1_data[40:28]);
  assign in_request = $signed(s1_data[56:41]);

  assign request_ok = !in_request[15] && (in_request < $signed(16'(NUM_POSITIONS)));

  assign window_fail = (in_left  < $signed({2'b00, left_min}))  ||
                       (in_left  > $signed({2'b00, left_max}))  ||
                       (in_front < $signed({2'b00, front_min})) ||
                       (in_front > $signed({2'b00, front_max})) ||
                       (in_angle > ANGLE_WINDOW) || (in_angle < -ANGLE_WINDOW);

  assign err_left  = $signed({3'b000, left_target}) - $signed({in_left[13], in_left});
  assign err_front = $signed({3'b000, front_target(target_index)}) -
                     $signed({in_front[13], in_front});
  assign err_angle = -$signed({in_angle[12], in_angle[12], in_angle});

  assign unset_left  = err_mag(err_left)  > {5'd0, left_deadband};
  assign unset_front = err_mag(err_front) > {5'd0, front_deadband};
  assign unset_angle = err_mag(err_angle) > {5'd0, angle_deadband};

  assign v_left  = unset_left  ? axis_vel(err_left,  SIDE_VMIN, SIDE_VMAX) : 11'sd0;
  assign v_front = unset_front ? axis_vel(err_front, FWD_VMIN,  FWD_VMAX)  : 11'sd0;
  assign v_turn  = unset_angle ? axis_vel(err_angle, TURN_VMIN, TURN_VMAX) : 11'sd0;

  assign all_inc = (all_count == ALL_COUNT_MAX) ? ALL_COUNT_MAX : all_count + 3'd1;

  always_comb begin
    target_valid_next = target_valid;
    target_index_next = target_index;
    left_count_next   = left_count;
    front_count_next  = front_count;
    angle_count_next  = angle_count;
    all_count_next    = all_count;
    res_valid         = 1'b0;
    res_vf            = v_front;
    res_vs            = v_left[8:0];
    res_vt            = v_turn[9:0];
    res_status        = STATUS_MOVING;
    all_ok            = 1'b0;

    if (s1_mode) begin
      if (request_ok) begin
        target_valid_next = 1'b1;
        target_index_next = in_request[1:0];
      end
    end else if (!target_valid) begin
      left_count_next  = 4'd0;
      front_count_next = 4'd0;
      angle_count_next = 4'd0;
      all_count_next   = 3'd0;
    end else if (window_fail) begin
      target_valid_next = 1'b0;
      res_valid         = 1'b1;
      res_vf            = 11'sd0;
      res_vs            = 9'sd0;
      res_vt            = 10'sd0;
      res_status        = STATUS_STOP;
    end else begin
      res_valid        = 1'b1;
      left_count_next  = count_step(unset_left,  left_count);
      front_count_next = count_step(unset_front, front_count);
      angle_count_next = count_step(unset_angle, angle_count);
      all_ok = !unset_left  && (left_count_next  >= LEFT_SETTLE_NEED)  &&
               !unset_front && (front_count_next >= FRONT_SETTLE_NEED) &&
               !unset_angle && (angle_count_next >= ANGLE_SETTLE_NEED);
      if (all_ok) begin
        all_count_next = all_inc;
        if (all_inc >= ALL_SETTLE_NEED) begin
          target_valid_next = 1'b0;
          res_status        = STATUS_ARRIVED;
        end
      end else begin
        all_count_next = 3'd0;
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign s1_fire  = s1_valid && (!res_valid || out_free);
  assign s_tready = !s1_valid || s1_fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_target    <= LEFT_TARGET_RST;
      left_deadband  <= LEFT_DEADBAND_RST;
      front_deadband <= FRONT_DEADBAND_RST;
      angle_deadband <= ANGLE_DEADBAND_RST;
      left_min       <= LEFT_MIN_RST;
      left_max       <= LEFT_MAX_RST;
      front_min      <= FRONT_MIN_RST;
      front_max      <= FRONT_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_TARGET:    left_target    <= cfg_data;
        REG_LEFT_DEADBAND:  left_deadband  <= cfg_data[9:0];
        REG_FRONT_DEADBAND: front_deadband <= cfg_data[9:0];
        REG_ANGLE_DEADBAND: angle_deadband <= cfg_data[9:0];
        REG_LEFT_MIN:       left_min       <= cfg_data;
        REG_LEFT_MAX:       left_max       <= cfg_data;
        REG_FRONT_MIN:      front_min      <= cfg_data;
        REG_FRONT_MAX:      front_max      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Controller state advances only when the held item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_valid <= 1'b0;
      target_index <= 2'd0;
      left_count   <= 4'd0;
      front_count  <= 4'd0;
      angle_count  <= 4'd0;
      all_count    <= 3'd0;
    end else if (s1_fire) begin
      target_valid <= target_valid_next;
      target_index <= target_index_next;
      left_count   <= left_count_next;
      front_count  <= front_count_next;
      angle_count  <= angle_count_next;
      all_count    <= all_count_next;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_mode <= s_tuser;
      s1_data <= s_tdata[56:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      m_tdata <= {2'b00, res_vt, res_vs, res_vf};
      m_tuser <= res_status;
    end
  end

  // An arrival or a stop never carries motion.
  a_halt_zero_vel: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == STATUS_ARRIVED || m_tuser == STATUS_STOP))
      |-> (m_tdata == 32'd0))
    else $error("arrival or stop result with nonzero velocity");

  // A result that ends the run drops the target.
  a_drop_target: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && res_valid && res_status != STATUS_MOVING) |=> !target_valid)
    else $error("target still active after arrival or stop");

  // A held item is not lost or altered while it waits.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |=> (s1_valid && $stable(s1_data) && $stable(s1_mode)))
    else $error("held input item changed while waiting");

  // Arrival needs a settled history of at least the required length.
  a_arrive_count: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && res_valid && res_status == STATUS_ARRIVED)
      |=> (all_count >= ALL_SETTLE_NEED))
    else $error("arrival reported without enough settled ticks");

endmodule

[verif/tb_planar_base_position_settle_controller_core.sv]
// Self-checking testbench for planar_base_position_settle_controller_core.
// Needs pbsc_pkg and the core RTL. A behavioral model of the settle
// controller predicts every result, and the testbench checks each result field by field.
`timescale 1ns / 1ps

module tb_planar_base_position_settle_controller_core;
  import pbsc_pkg::*;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_CMD  = 1'b1;

  localparam int NUM_TARGETS  = NUM_POSITIONS;
  localparam int ANGLE_LIMIT  = 500;
  localparam int NEED_LEFT    = 4;
  localparam int NEED_FRONT   = 5;
  localparam int NEED_ANGLE   = 4;
  localparam int NEED_ALL     = 6;
  localparam int AXIS_CNT_TOP = 15;
  localparam int ALL_CNT_TOP  = 7;
  localparam int FWD_LO = 100, FWD_HI = 600;
  localparam int SIDE_LO = 100, SIDE_HI = 200;
  localparam int TURN_LO = 100, TURN_HI = 300;
  localparam int FRONT_GOAL_MM [4] = '{2200, 1600, 1000, 400};

  localparam int PIPE_CYCLES = 4;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic               mode;
    logic signed [13:0] left_mm;
    logic signed [13:0] front_mm;
    logic signed [12:0] angle_mrad;
    logic signed [15:0] request;
  } base_item_t;

  typedef struct packed {
    logic signed [10:0] vel_fwd;
    logic signed [8:0]  vel_side;
    logic signed [9:0]  vel_turn;
    status_t            status;
  } velocity_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  planar_base_position_settle_controller_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Controller model state and register copies.
  logic [11:0] m_left_target, m_left_min, m_left_max, m_front_min, m_front_max;
  logic [9:0]  m_left_band, m_front_band, m_angle_band;
  bit          has_target;
  logic [1:0]  target_sel;
  logic [3:0]  cnt_left, cnt_front, cnt_angle;
  logic [2:0]  cnt_all;

  velocity_cmd_t pending_vel_cmds[$];

  int n_errors = 0;
  int n_items = 0, n_effective = 0, n_moving = 0, n_stops = 0, n_arrivals = 0;
  int n_configs = 0;
  int src_idle_pct = 0, dst_idle_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  function automatic int pick(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic void reset_controller_model();
    m_left_target = 12'd260;  m_left_band = 10'd50;  m_front_band = 10'd30;
    m_angle_band = 10'd30;    m_left_min = 12'd100;  m_left_max = 12'd1000;
    m_front_min = 12'd150;    m_front_max = 12'd2250;
    has_target = 1'b0;  target_sel = '0;
    cnt_left = '0;  cnt_front = '0;  cnt_angle = '0;  cnt_all = '0;
  endfunction

  // One axis: velocity opposes the error once it leaves the deadband.
  function automatic int settle_axis(input int err, input int band, inout logic [3:0] cnt,
                                     input int need, input int vmin, input int vmax,
                                     inout bit ok);
    int mag;
    mag = (err < 0) ? -err : err;
    if (mag > band) begin
      ok = 1'b0;
      cnt = '0;
      if (mag > vmax) mag = vmax;
      if (mag < vmin) mag = vmin;
      return (err < 0) ? mag : -mag;
    end
    if (int'(cnt) < AXIS_CNT_TOP) cnt = cnt + 4'd1;
    if (int'(cnt) < need) ok = 1'b0;
    return 0;
  endfunction

  function automatic bit advance_controller(input base_item_t c, output velocity_cmd_t r);
    int  req, left, front, ang, vf, vs, vt;
    bit  ok;
    r = '0;
    r.status = STATUS_MOVING;
    if (c.mode == MODE_CMD) begin
      req = int'(c.request);
      if (req >= 0 && req < NUM_TARGETS) begin
        has_target = 1'b1;
        target_sel = req[1:0];
      end
      return 1'b0;
    end
    if (!has_target) begin
      cnt_left = '0;  cnt_front = '0;  cnt_angle = '0;  cnt_all = '0;
      return 1'b0;
    end
    left  = int'(c.left_mm);
    front = int'(c.front_mm);
    ang   = int'(c.angle_mrad);
    if (left < int'(m_left_min) || left > int'(m_left_max) ||
        front < int'(m_front_min) || front > int'(m_front_max) ||
        ang > ANGLE_LIMIT || ang < -ANGLE_LIMIT) begin
      has_target = 1'b0;
      r.status = STATUS_STOP;
      return 1'b1;
    end
    ok = 1'b1;
    vs = settle_axis(int'(m_left_target) - left, int'(m_left_band), cnt_left, NEED_LEFT,
                     SIDE_LO, SIDE_HI, ok);
    vf = settle_axis(FRONT_GOAL_MM[target_sel] - front, int'(m_front_band), cnt_front,
                     NEED_FRONT, FWD_LO, FWD_HI, ok);
    vt = settle_axis(-ang, int'(m_angle_band), cnt_angle, NEED_ANGLE, TURN_LO, TURN_HI, ok);
    if (ok) begin
      if (int'(cnt_all) < ALL_CNT_TOP) cnt_all = cnt_all + 3'd1;
      if (int'(cnt_all) >= NEED_ALL) begin
        has_target = 1'b0;
        r.status = STATUS_ARRIVED;
      end
    end else begin
      cnt_all = '0;
    end
    r.vel_fwd  = vf[10:0];
    r.vel_side = vs[8:0];
    r.vel_turn = vt[9:0];
    return 1'b1;
  endfunction

  function automatic base_item_t make_tick(int l, int f, int a);
    base_item_t c;
    c = '0;
    c.mode = MODE_TICK;
    c.left_mm = l[13:0];
    c.front_mm = f[13:0];
    c.angle_mrad = a[12:0];
    return c;
  endfunction

  function automatic base_item_t make_cmd(int req);
    base_item_t c;
    c = '0;
    c.mode = MODE_CMD;
    c.request = req[15:0];
    return c;
  endfunction

  // A tick inside the allowed windows, optionally inside every deadband too.
  function automatic base_item_t settle_tick(bit in_band);
    int lo_l, hi_l, lo_f, hi_f, goal, a;
    goal = FRONT_GOAL_MM[target_sel];
    lo_l = int'(m_left_min);  hi_l = int'(m_left_max);
    lo_f = int'(m_front_min); hi_f = int'(m_front_max);
    a = ANGLE_LIMIT;
    if (in_band) begin
      if (int'(m_left_target) - int'(m_left_band) > lo_l)
        lo_l = int'(m_left_target) - int'(m_left_band);
      if (int'(m_left_target) + int'(m_left_band) < hi_l)
        hi_l = int'(m_left_target) + int'(m_left_band);
      if (goal - int'(m_front_band) > lo_f) lo_f = goal - int'(m_front_band);
      if (goal + int'(m_front_band) < hi_f) hi_f = goal + int'(m_front_band);
      if (int'(m_angle_band) < a) a = int'(m_angle_band);
    end
    return make_tick(pick(lo_l, hi_l), pick(lo_f, hi_f), pick(-a, a));
  endfunction

  function automatic base_item_t noise_item();
    base_item_t c;
    c.mode = 1'($urandom_range(1));
    c.left_mm = 14'($urandom);
    c.front_mm = 14'($urandom);
    c.angle_mrad = 13'(pick(-3142, 3142));
    c.request = ($urandom_range(1) != 0) ? 16'($urandom) : 16'(pick(-2, 5));
    return c;
  endfunction

  task automatic send_item(input base_item_t c);
    velocity_cmd_t r;
    bit            acts;
    while (int'($urandom_range(99)) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.mode;
    s_tdata  <= {7'd0, c.request, c.angle_mrad, c.front_mm, c.left_mm};
    do @(negedge clk); while (s_tready !== 1'b1);
    @(posedge clk);
    n_items++;
    acts = (c.mode == MODE_CMD) ? (c.request >= 0 && c.request < NUM_TARGETS) : has_target;
    if (acts) n_effective++;
    if (advance_controller(c, r)) begin
      pending_vel_cmds.push_back(r);
      case (r.status)
        STATUS_STOP:    n_stops++;
        STATUS_ARRIVED: n_arrivals++;
        default:        n_moving++;
      endcase
    end
  endtask

  // Stop offering items, wait for every outstanding result, then let the pipe empty.
  task automatic drain(input int extra_cycles);
    s_tvalid <= 1'b0;
    while (pending_vel_cmds.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[11:0];
    @(posedge clk);
    case (idx)
      REG_LEFT_TARGET:    m_left_target = val[11:0];
      REG_LEFT_DEADBAND:  m_left_band   = val[9:0];
      REG_FRONT_DEADBAND: m_front_band  = val[9:0];
      REG_ANGLE_DEADBAND: m_angle_band  = val[9:0];
      REG_LEFT_MIN:       m_left_min    = val[11:0];
      REG_LEFT_MAX:       m_left_max    = val[11:0];
      REG_FRONT_MIN:      m_front_min   = val[11:0];
      default:            m_front_max   = val[11:0];
    endcase
  endtask

  task automatic apply_config(input int lt, input int lb, input int fb, input int ab,
                              input int lmin, input int lmax, input int fmin, input int fmax);
    drain(PIPE_CYCLES);
    set_reg(REG_LEFT_TARGET, lt);
    set_reg(REG_LEFT_DEADBAND, lb);
    set_reg(REG_FRONT_DEADBAND, fb);
    set_reg(REG_ANGLE_DEADBAND, ab);
    set_reg(REG_LEFT_MIN, lmin);
    set_reg(REG_LEFT_MAX, lmax);
    set_reg(REG_FRONT_MIN, fmin);
    set_reg(REG_FRONT_MAX, fmax);
    cfg_we <= 1'b0;
    n_configs++;
  endtask

  task automatic set_idling(input int src_pct, input int dst_pct);
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
  endtask

  // Command a target, approach it, then send mostly in-deadband ticks until the target drops or twelve ticks have gone.
  task automatic run_settle_sequence();
    int k;
    send_item(make_cmd(pick(0, NUM_TARGETS - 1)));
    repeat (pick(0, 3)) if (has_target) send_item(settle_tick(1'b0));
    for (int i = 0; i < 12 && has_target; i++) begin
      k = $urandom_range(99);
      if (k < 3) send_item(noise_item());
      else if (k < 8) send_item(settle_tick(1'b0));
      else send_item(settle_tick(1'b1));
    end
  endtask

  task automatic run_traffic(input int count);
    int goal;
    goal = n_effective + count;
    while (n_effective < goal) begin
      if ($urandom_range(9) < 7) run_settle_sequence();
      else send_item(noise_item());
    end
  endtask

  task automatic random_config();
    int lt;
    lt = pick(0, 1500);
    apply_config(lt, pick(0, 120), pick(0, 120), pick(0, 120),
                 pick(0, lt), pick(lt, 4095), pick(0, 400), pick(2200, 4095));
  endtask

  task automatic test_directed();
    set_idling(35, 70);
    send_item(make_tick(0, 0, 0));            // no target yet
    send_item(make_cmd(-32768));
    send_item(make_cmd(32767));
    send_item(make_cmd(NUM_TARGETS));
    send_item(make_cmd(-1));
    send_item(make_tick(260, 2200, 0));       // still no target
    send_item(make_cmd(3));
    send_item(make_tick(-8192, -8192, -3142));
    send_item(make_cmd(0));
    send_item(make_tick(8191, 8191, 3142));
    send_item(make_cmd(1));
    send_item(make_tick(260, 1600, 501));     // angle just outside its window
    send_item(make_cmd(0));
    send_item(make_tick(100, 150, -500));     // window edges, forward and turn clamp at their upper limits
    send_item(make_tick(209, 2231, 31));      // just outside deadbands, clamp at the minimum
    send_item(make_tick(1000, 2250, 500));
    // Ten ticks on the deadband edges lead to arrival.
    for (int i = 0; i < 10; i++)
      send_item(i[0] ? make_tick(210, 2170, -30) : make_tick(310, 2230, 30));
  endtask

  task automatic test_register_extremes();
    apply_config(0, 0, 0, 0, 0, 0, 0, 0);
    run_traffic(30);
    apply_config(4095, 1023, 1023, 1023, 4095, 4095, 4095, 4095);
    run_traffic(30);
    apply_config(pick(0, 1000), 20, 20, 20, 0, 4095, 0, 4095);
    run_traffic(30);
    // Inverted windows: every tick with a target stops the base.
    apply_config(260, 50, 30, 30, 1000, 100, 2250, 150);
    run_traffic(30);
    apply_config(260, 50, 30, 30, 100, 1000, 150, 2250);
    run_traffic(30);
  endtask

  task automatic test_random_traffic();
    set_idling(35, 70);
    random_config();
    run_traffic(110);
    set_idling(70, 35);
    random_config();
    run_traffic(110);
    set_idling(0, 0);
    random_config();
    run_traffic(110);
  endtask

  // The receiver holds off while items keep coming, so the block backs up.
  task automatic test_receiver_hold();
    set_idling(0, 0);
    stall_left <= HOLD_CYCLES;
    run_traffic(30);
  endtask

  task automatic test_sender_pause();
    set_idling(35, 70);
    run_traffic(20);
    drain(0);
    run_traffic(20);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= (int'($urandom_range(99)) >= dst_idle_pct);
    end
  end

  task automatic report_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Handshake signals are stable from the falling edge to the accepting rising edge.
  always @(negedge clk) begin : check_results
    velocity_cmd_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (pending_vel_cmds.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual m_tdata %h m_tuser %0d",
                 $time, m_tdata, m_tuser);
        n_errors++;
      end else begin
        want = pending_vel_cmds.pop_front();
        report_field("vel_forward", want.vel_fwd, $signed(m_tdata[10:0]));
        report_field("vel_sideways", want.vel_side, $signed(m_tdata[19:11]));
        report_field("vel_turn", want.vel_turn, $signed(m_tdata[29:20]));
        report_field("status", want.status, m_tuser);
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending_vel_cmds.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    reset_controller_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_traffic();
    test_receiver_hold();
    test_sender_pause();
    drain(PIPE_CYCLES);
    $display("Sent %0d transactions (%0d acting on the controller) across %0d register settings.",
             n_items, n_effective, n_configs);
    $display("Checked %0d moving results, %0d out-of-range stops and %0d arrivals.",
             n_moving, n_stops, n_arrivals);
    if (n_errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
